// ----- hw/rtl/tfcm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfcm_pkg: shared types and constants
// Codes, register indexes, state encoding and widths for the thermal frame
// contrast mirror.
// ----------------------------------------------------------------------------
package tfcm_pkg;

    // Pixel code width and type
    localparam int CODE_W = 8;
    typedef logic [CODE_W-1:0] code_t;

    // Special codes
    localparam code_t CODE_BELOW   = 8'd0;    // below-range sentinel
    localparam code_t CODE_ABOVE   = 8'd255;  // above-range sentinel
    localparam code_t CODE_SAT_LO  = 8'd1;    // lowest stretched code
    localparam code_t CODE_SAT_HI  = 8'd254;  // highest stretched code
    localparam code_t CODE_FLAT    = 8'd127;  // flat frame output
    localparam code_t STRETCH_SPAN = 8'd253;  // output span of the stretch

    // Stretch arithmetic: numerator (v-min)*253 fits 16 bits,
    // reciprocal floor(2^16 / span) needs 17 bits
    localparam int NUM_W       = 16;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int DIV_STEPS   = RECIP_W;
    localparam int DIV_CNT_W   = 5;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_AUTO_MODE    = 2'd0,
        REG_HAS_IN_RANGE = 2'd1,
        REG_MIN_ENCODED  = 2'd2,
        REG_MAX_ENCODED  = 2'd3
    } reg_index_t;

    // Control states
    typedef enum logic {
        ST_FILL,
        ST_EMIT
    } fsm_state_t;

    // Markers that travel with each display item
    typedef struct packed {
        logic row_end;
        logic frame_end;
    } out_tag_t;

endpackage : tfcm_pkg
`default_nettype wire

// ----- hw/rtl/thermal_frame_contrast_mirror.sv -----
// Once a row's last pixel is taken, its items are read from the row store right to left and
//   pass the mapping stages; they follow one per cycle while out_stall stays low.
// A row is taken, then emitted from the row store; in_stall is high while a row is emitted,
//   and after any register write emission waits for the reciprocal unit.
// Reset: rst_n clears counters, state, valids, configuration and reciprocal registers; the row store is not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// thermal_frame_contrast_mirror
// Min/max contrast stretch of encoded thermal pixels, each row held in a row
// store and sent out horizontally mirrored.
// ----------------------------------------------------------------------------
module thermal_frame_contrast_mirror
    import tfcm_pkg::*;
#(
    parameter int IMAGE_WIDTH  = 32,
    parameter int IMAGE_HEIGHT = 24
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // pixel input
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        pixel_code,
    // display output
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             display_code,
    output logic                   row_end,
    output logic                   frame_end,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = (IMAGE_HEIGHT > 1) ? $clog2(IMAGE_HEIGHT) : 1;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMAGE_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMAGE_HEIGHT - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic       auto_mode_reg;
    logic       has_in_range_reg;
    code_t      min_encoded_reg;
    code_t      max_encoded_reg;
    logic       cfg_wr;
    reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_mode_reg    <= 1'b0;
            has_in_range_reg <= 1'b0;
            min_encoded_reg  <= CODE_SAT_LO;
            max_encoded_reg  <= CODE_SAT_HI;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_AUTO_MODE:    auto_mode_reg    <= pwdata[0];
                REG_HAS_IN_RANGE: has_in_range_reg <= pwdata[0];
                REG_MIN_ENCODED:  min_encoded_reg  <= pwdata[CODE_W-1:0];
                REG_MAX_ENCODED:  max_encoded_reg  <= pwdata[CODE_W-1:0];
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_AUTO_MODE:    prdata = DATA_W'(auto_mode_reg);
            REG_HAS_IN_RANGE: prdata = DATA_W'(has_in_range_reg);
            REG_MIN_ENCODED:  prdata = DATA_W'(min_encoded_reg);
            REG_MAX_ENCODED:  prdata = DATA_W'(max_encoded_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Reciprocal unit: floor(2^16 / (max - min)), one quotient bit a cycle
    // ------------------------------------------------------------------
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    code_t                div_rem_reg;
    logic [RECIP_W-1:0]   div_q_reg;
    code_t                span;
    logic                 div_done;
    logic [CODE_W:0]      div_trial;
    logic [CODE_W:0]      div_diff;
    logic                 div_ge;

    assign span      = max_encoded_reg - min_encoded_reg;
    assign div_done  = (div_cnt_reg == '0);
    // dividend is a single 1 in its top bit
    assign div_trial = {div_rem_reg, (div_cnt_reg == DIV_CNT_W'(DIV_STEPS))};
    assign div_diff  = div_trial - {1'b0, span};
    assign div_ge    = (div_trial >= {1'b0, span});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS);
            div_rem_reg <= '0;
            div_q_reg   <= '0;
        end
        else if (!div_done)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            div_rem_reg <= div_ge ? div_diff[CODE_W-1:0] : div_trial[CODE_W-1:0];
            div_q_reg   <= {div_q_reg[RECIP_W-2:0], div_ge};
        end
    end

    // ------------------------------------------------------------------
    // Control state machine
    // ------------------------------------------------------------------
    fsm_state_t       state_reg;
    fsm_state_t       state_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] rd_col_reg;
    logic [ROW_W-1:0] row_reg;
    logic             frame_last_reg;
    logic             in_acc;
    logic             adv;
    logic             emit_active;
    logic             issue;
    logic             col_last;

    assign in_acc   = in_valid && !in_stall;
    assign col_last = (col_reg == COL_LAST);
    assign adv      = !out_valid || !out_stall;
    assign issue    = emit_active && div_done && adv;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_FILL:
            begin
                if (in_acc && col_last)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (issue && (rd_col_reg == '0))
                    state_next = ST_FILL;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        unique case (state_reg)
            ST_FILL:
            begin
                in_stall    = 1'b0;
                emit_active = 1'b0;
            end
            ST_EMIT:
            begin
                in_stall    = 1'b1;
                emit_active = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_FILL;
            col_reg        <= '0;
            row_reg        <= '0;
            rd_col_reg     <= '0;
            frame_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
            begin
                col_reg <= col_last ? '0 : col_reg + 1'b1;
                if (col_last)
                begin
                    row_reg        <= (row_reg == ROW_LAST) ? '0 : row_reg + 1'b1;
                    frame_last_reg <= (row_reg == ROW_LAST);
                    rd_col_reg     <= COL_LAST;
                end
            end
            else if (issue)
            begin
                rd_col_reg <= rd_col_reg - 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Row store: written in column order, read right to left
    // ------------------------------------------------------------------
    code_t row_mem [IMAGE_WIDTH];
    code_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
            row_mem[col_reg] <= pixel_code;
        if (issue)
            rd_data_reg <= row_mem[rd_col_reg];
    end

    out_tag_t issue_tag;
    always_comb
    begin
        issue_tag.row_end   = (rd_col_reg == '0);
        issue_tag.frame_end = (rd_col_reg == '0) && frame_last_reg;
    end

    // ------------------------------------------------------------------
    // Mapping pipeline, all stages advance together on adv
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    out_tag_t         s1_tag_reg;
    logic             s2_valid_reg;
    out_tag_t         s2_tag_reg;
    logic             s2_div_reg;
    code_t            s2_code_reg;
    logic [NUM_W-1:0] s2_num_reg;
    logic             s3_valid_reg;
    out_tag_t         s3_tag_reg;
    logic             s3_div_reg;
    code_t            s3_code_reg;
    logic [NUM_W-1:0] s3_num_reg;
    code_t            s3_qest_reg;
    logic             out_valid_reg;
    code_t            display_code_reg;
    out_tag_t         out_tag_reg;

    // stage 1: classify the code and form (v - min) * 253
    logic             s2_div_next;
    code_t            s2_code_next;
    logic [NUM_W-1:0] s2_num_next;
    code_t            delta;

    assign delta       = rd_data_reg - min_encoded_reg;
    assign s2_num_next = NUM_W'(delta) * NUM_W'(STRETCH_SPAN);

    always_comb
    begin
        s2_div_next  = 1'b0;
        s2_code_next = rd_data_reg;
        priority if (!auto_mode_reg || !has_in_range_reg)
            s2_code_next = rd_data_reg;
        else if ((rd_data_reg == CODE_BELOW) || (rd_data_reg == CODE_ABOVE))
            s2_code_next = rd_data_reg;
        else if (max_encoded_reg <= min_encoded_reg)
            s2_code_next = CODE_FLAT;
        else if (rd_data_reg <= min_encoded_reg)
            s2_code_next = CODE_SAT_LO;
        else if (rd_data_reg >= max_encoded_reg)
            s2_code_next = CODE_SAT_HI;
        else
            s2_div_next = 1'b1;
    end

    // stage 2: quotient estimate by reciprocal multiply
    logic [NUM_W+RECIP_W-1:0] recip_prod;
    assign recip_prod = (NUM_W+RECIP_W)'(s2_num_reg) * (NUM_W+RECIP_W)'(div_q_reg);

    // stage 3: one correction step on the estimate
    logic [NUM_W-1:0] qd;
    logic [NUM_W-1:0] rem;
    logic             fix;
    code_t            stretch_code;

    assign qd           = NUM_W'(s3_qest_reg) * NUM_W'(span);
    assign rem          = s3_num_reg - qd;
    assign fix          = (rem >= NUM_W'(span));
    assign stretch_code = CODE_SAT_LO + s3_qest_reg + CODE_W'(fix);

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= issue;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_tag_reg       <= issue_tag;
            s2_tag_reg       <= s1_tag_reg;
            s2_div_reg       <= s2_div_next;
            s2_code_reg      <= s2_code_next;
            s2_num_reg       <= s2_num_next;
            s3_tag_reg       <= s2_tag_reg;
            s3_div_reg       <= s2_div_reg;
            s3_code_reg      <= s2_code_reg;
            s3_num_reg       <= s2_num_reg;
            s3_qest_reg      <= recip_prod[RECIP_SHIFT +: CODE_W];
            out_tag_reg      <= s3_tag_reg;
            display_code_reg <= s3_div_reg ? stretch_code : s3_code_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign display_code = display_code_reg;
    assign row_end      = out_tag_reg.row_end;
    assign frame_end    = out_tag_reg.frame_end;

endmodule : thermal_frame_contrast_mirror
`default_nettype wire

// ----- hw/rtl/tfcm_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfcm_checker
// Port-level checks for the thermal frame contrast mirror, bound to the top.
// ----------------------------------------------------------------------------
module tfcm_checker
    import tfcm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [7:0]        pixel_code,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [7:0]        display_code,
    input wire logic              row_end,
    input wire logic              frame_end,
    input wire logic              psel,
    input wire logic              penable,
    input wire logic              pwrite,
    input wire logic [ADDR_W-1:0] paddr,
    input wire logic [DATA_W-1:0] pwdata,
    input wire logic [DATA_W-1:0] prdata,
    input wire logic              pready
);

    // a stalled pixel item holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(pixel_code))
        else $error("stalled pixel item changed");

    // a frame ends only on the last item of a row
    a_frame_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    // a stalled display item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(display_code)
            && $stable(row_end) && $stable(frame_end))
        else $error("stalled display item changed");

    // min register reads back what was written
    a_min_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == REG_MIN_ENCODED))
            ##1 (paddr[3:2] == REG_MIN_ENCODED)
        |-> (prdata[7:0] == $past(pwdata[7:0])))
        else $error("min_encoded readback mismatch");

    // max register reads back what was written
    a_max_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == REG_MAX_ENCODED))
            ##1 (paddr[3:2] == REG_MAX_ENCODED)
        |-> (prdata[7:0] == $past(pwdata[7:0])))
        else $error("max_encoded readback mismatch");

endmodule : tfcm_checker

bind thermal_frame_contrast_mirror tfcm_checker u_tfcm_checker (.*);
`default_nettype wire

// ----- bench/thermal_frame_contrast_mirror_test.sv -----
// ----------------------------------------------------------------------------
// thermal_frame_contrast_mirror_test
// Self-checking bench for the contrast stretch and row mirror. A directed
// table covers the sentinel codes, saturation, flat and inverted bounds, raw
// and pass-through modes. Random phases follow, each with new register
// settings, random pixel streams and random idling on both item channels.
// Every display item is checked against a predictor held in the bench.
// ----------------------------------------------------------------------------
module thermal_frame_contrast_mirror_test;
    import tfcm_pkg::*;

    localparam int ROW_PIXELS    = 32;
    localparam int FRAME_ROWS    = 24;
    localparam int RANDOM_ITEMS  = 206;
    localparam int SETTLE_CYCLES = 30;     // emit latency plus reciprocal restart
    localparam int LONG_HOLD     = 300;
    localparam int MAX_REPORTS   = 10;

    // Directed table entry kinds
    typedef enum logic [1:0] {
        DIR_SET,
        DIR_PIXEL,
        DIR_PAD
    } dir_kind_t;

    typedef struct packed {
        dir_kind_t  kind;
        reg_index_t idx;
        code_t      val;
        logic       has_want;
        code_t      want;
    } dir_entry_t;

    typedef struct packed {
        code_t code;
        logic  row_end;
        logic  frame_end;
    } display_item_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        pixel_code;
    logic              out_valid;
    logic              out_stall;
    logic [7:0]        display_code;
    logic              row_end;
    logic              frame_end;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    thermal_frame_contrast_mirror #(
        .IMAGE_WIDTH  (ROW_PIXELS),
        .IMAGE_HEIGHT (FRAME_ROWS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pixel_code   (pixel_code),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .display_code (display_code),
        .row_end      (row_end),
        .frame_end    (frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Predictor state: register copies, row buffer, position in frame
    logic  auto_on       = 1'b0;
    logic  in_range_seen = 1'b0;
    code_t lo_code       = CODE_SAT_LO;
    code_t hi_code       = CODE_SAT_HI;
    code_t row_buf   [ROW_PIXELS];
    logic  want_set  [ROW_PIXELS];
    code_t want_code [ROW_PIXELS];
    int    fill_column = 0;
    int    row_count   = 0;

    display_item_t pending_display[$];

    // Run bookkeeping
    int   fail_count     = 0;
    int   pixels_sent    = 0;
    int   random_pixels  = 0;
    int   rows_done      = 0;
    int   frames_done    = 0;
    int   items_checked  = 0;
    int   phase_count    = 0;
    logic source_quiet   = 1'b0;
    logic sink_quiet     = 1'b0;
    logic long_hold_req  = 1'b0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // Stretch mapping of one code under the current registers
    function automatic code_t contrast_map(code_t v);
        if (!auto_on || !in_range_seen)
            return v;
        if (v == CODE_BELOW || v == CODE_ABOVE)
            return v;
        if (hi_code <= lo_code)
            return CODE_FLAT;
        if (v <= lo_code)
            return CODE_SAT_LO;
        if (v >= hi_code)
            return CODE_SAT_HI;
        return code_t'(int'(CODE_SAT_LO) + ((int'(v) - int'(lo_code)) * int'(STRETCH_SPAN))
                       / (int'(hi_code) - int'(lo_code)));
    endfunction

    // Store one pixel; on the last column queue the mirrored row
    task automatic take_pixel(code_t v, logic has_w, code_t w);
        logic          last_row;
        display_item_t item;
        int            src;
        row_buf[fill_column]   = v;
        want_set[fill_column]  = has_w;
        want_code[fill_column] = w;
        if (fill_column < ROW_PIXELS - 1)
        begin
            fill_column++;
            return;
        end
        last_row = (row_count == FRAME_ROWS - 1);
        for (int k = 0; k < ROW_PIXELS; k++)
        begin
            src            = ROW_PIXELS - 1 - k;
            item.code      = want_set[src] ? want_code[src] : contrast_map(row_buf[src]);
            item.row_end   = (k == ROW_PIXELS - 1);
            item.frame_end = item.row_end && last_row;
            pending_display.push_back(item);
        end
        fill_column = 0;
        row_count   = last_row ? 0 : row_count + 1;
        rows_done++;
        if (last_row)
            frames_done++;
    endtask

    // Idle length: mostly none or short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Pixel mix: sentinels, full range, and codes around the current bounds
    function automatic code_t pick_pixel();
        int r;
        int lo;
        int hi;
        r  = $urandom_range(0, 9);
        lo = (int'(lo_code) > 4) ? int'(lo_code) - 3 : 1;
        hi = (int'(hi_code) < 251) ? int'(hi_code) + 3 : 254;
        if (r == 0)
            return CODE_BELOW;
        if (r == 1)
            return CODE_ABOVE;
        if (r < 4)
            return code_t'($urandom_range(0, 255));
        return code_t'($urandom_range(lo, hi));
    endfunction

    function automatic dir_entry_t set_reg(reg_index_t i, code_t v);
        return '{DIR_SET, i, v, 1'b0, 8'd0};
    endfunction

    function automatic dir_entry_t pix_known(code_t v, code_t w);
        return '{DIR_PIXEL, REG_AUTO_MODE, v, 1'b1, w};
    endfunction

    function automatic dir_entry_t pix_predict(code_t v);
        return '{DIR_PIXEL, REG_AUTO_MODE, v, 1'b0, 8'd0};
    endfunction

    function automatic dir_entry_t pad_row();
        return '{DIR_PAD, REG_AUTO_MODE, 8'd0, 1'b0, 8'd0};
    endfunction

    // Log a failure; only the first few are printed
    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // Offer one pixel item and hold it until taken
    task automatic send_pixel(code_t v, logic has_w, code_t w);
        int gap;
        gap = source_quiet ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        pixel_code <= v;
        do
            @(posedge clk);
        while (in_stall);
        take_pixel(v, has_w, w);
        pixels_sent++;
    endtask

    // Stop sending, wait for all display items, then let the block settle
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_display.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write followed by a read back
    task automatic cfg_write(reg_index_t idx, code_t val);
        logic [DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_AUTO_MODE:    auto_on       = val[0];
            REG_HAS_IN_RANGE: in_range_seen = val[0];
            REG_MIN_ENCODED:  lo_code       = val;
            REG_MAX_ENCODED:  hi_code       = val;
            default:          ;
        endcase
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== DATA_W'(val))
            note_failure($sformatf("register %s read back %0h, expected %0h",
                                   idx.name(), readback, val));
    endtask

    task automatic apply_settings(logic a, logic h, code_t lo, code_t hi);
        wait_until_idle();
        cfg_write(REG_AUTO_MODE, code_t'(a));
        cfg_write(REG_HAS_IN_RANGE, code_t'(h));
        cfg_write(REG_MIN_ENCODED, lo);
        cfg_write(REG_MAX_ENCODED, hi);
    endtask

    // Compare one taken display item with the oldest expectation
    task automatic check_display_item();
        display_item_t want;
        if (pending_display.size() == 0)
        begin
            note_failure($sformatf("unexpected display item: code %0d row_end %0b frame_end %0b",
                                   display_code, row_end, frame_end));
            return;
        end
        want = pending_display.pop_front();
        items_checked++;
        if (display_code !== want.code || row_end !== want.row_end
            || frame_end !== want.frame_end)
            note_failure($sformatf(
                "mismatch: expected code %0d row_end %0b frame_end %0b, got %0d %0b %0b",
                want.code, want.row_end, want.frame_end, display_code, row_end, frame_end));
    endtask

    // Display side: check taken items, drive random and long stalls
    initial
    begin : display_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                check_display_item();
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!sink_quiet && $urandom_range(0, 3) == 0)
                    stall_left = idle_gap();
            end
        end
    end

    // Pixel side: reset, directed table, random phases, final drain
    initial
    begin : pixel_source
        dir_entry_t directed_table[$];
        logic       a;
        logic       h;
        code_t      lo;
        code_t      hi;
        int         n;
        int         profile;

        in_valid   <= 1'b0;
        pixel_code <= 8'd0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        rst_n      <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // raw mode after reset: every code passes unchanged
        directed_table.push_back(pix_known(8'd0, 8'd0));
        directed_table.push_back(pix_known(8'd255, 8'd255));
        directed_table.push_back(pix_known(8'd1, 8'd1));
        directed_table.push_back(pix_known(8'd254, 8'd254));
        directed_table.push_back(pix_known(8'h55, 8'h55));
        directed_table.push_back(pix_known(8'hAA, 8'hAA));
        directed_table.push_back(pad_row());
        // auto mode but no in-range pixel in frame: pass-through
        directed_table.push_back(set_reg(REG_AUTO_MODE, 8'd1));
        directed_table.push_back(pix_known(8'd37, 8'd37));
        directed_table.push_back(pad_row());
        // stretch between 50 and 200: sentinels, saturation at both ends
        directed_table.push_back(set_reg(REG_HAS_IN_RANGE, 8'd1));
        directed_table.push_back(set_reg(REG_MIN_ENCODED, 8'd50));
        directed_table.push_back(set_reg(REG_MAX_ENCODED, 8'd200));
        directed_table.push_back(pix_known(8'd0, CODE_BELOW));
        directed_table.push_back(pix_known(8'd255, CODE_ABOVE));
        directed_table.push_back(pix_known(8'd49, CODE_SAT_LO));
        directed_table.push_back(pix_known(8'd50, CODE_SAT_LO));
        directed_table.push_back(pix_known(8'd200, CODE_SAT_HI));
        directed_table.push_back(pix_known(8'd201, CODE_SAT_HI));
        directed_table.push_back(pix_predict(8'd125));
        directed_table.push_back(pad_row());
        // widest bounds
        directed_table.push_back(set_reg(REG_MIN_ENCODED, 8'd1));
        directed_table.push_back(set_reg(REG_MAX_ENCODED, 8'd254));
        directed_table.push_back(pix_known(8'd1, CODE_SAT_LO));
        directed_table.push_back(pix_known(8'd254, CODE_SAT_HI));
        directed_table.push_back(pix_predict(8'd2));
        directed_table.push_back(pad_row());
        // flat frame
        directed_table.push_back(set_reg(REG_MIN_ENCODED, 8'd100));
        directed_table.push_back(set_reg(REG_MAX_ENCODED, 8'd100));
        directed_table.push_back(pix_known(8'd100, CODE_FLAT));
        directed_table.push_back(pix_known(8'd0, CODE_BELOW));
        directed_table.push_back(pix_known(8'd255, CODE_ABOVE));
        directed_table.push_back(pad_row());
        // inverted bounds behave as a flat frame
        directed_table.push_back(set_reg(REG_MIN_ENCODED, 8'd200));
        directed_table.push_back(set_reg(REG_MAX_ENCODED, 8'd10));
        directed_table.push_back(pix_known(8'd5, CODE_FLAT));
        directed_table.push_back(pix_known(8'd250, CODE_FLAT));
        directed_table.push_back(pad_row());
        // back to raw
        directed_table.push_back(set_reg(REG_AUTO_MODE, 8'd0));
        directed_table.push_back(pix_known(8'd128, 8'd128));
        directed_table.push_back(pad_row());

        foreach (directed_table[i])
        begin
            case (directed_table[i].kind)
                DIR_SET:
                begin
                    wait_until_idle();
                    cfg_write(directed_table[i].idx, directed_table[i].val);
                end
                DIR_PIXEL:
                    send_pixel(directed_table[i].val, directed_table[i].has_want,
                               directed_table[i].want);
                default:
                    while (fill_column != 0)
                        send_pixel(pick_pixel(), 1'b0, 8'd0);
            endcase
        end

        // Random phases, each with fresh register settings
        while (random_pixels < RANDOM_ITEMS)
        begin
            profile = $urandom_range(0, 9);
            a  = 1'b1;
            h  = 1'b1;
            lo = code_t'($urandom_range(1, 200));
            hi = code_t'($urandom_range(int'(lo) + 1, 254));
            case (profile)
                0: a = 1'b0;
                1: h = 1'b0;
                2: hi = lo;
                3: begin lo = code_t'($urandom_range(2, 254));
                         hi = code_t'($urandom_range(1, int'(lo) - 1)); end
                4: begin lo = CODE_SAT_LO; hi = CODE_SAT_HI; end
                5: begin lo = CODE_SAT_HI; hi = CODE_SAT_LO; end
                6: hi = lo + 8'd1;
                default: ;
            endcase
            apply_settings(a, h, lo, hi);

            source_quiet = ($urandom_range(0, 3) == 0);
            sink_quiet   = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, ROW_PIXELS - 1);
            else
                n = ROW_PIXELS * $urandom_range(1, 3);
            // one phase where the display side holds off while pixels keep coming
            if (phase_count == 0)
            begin
                long_hold_req = 1'b1;
                source_quiet  = 1'b1;
                n             = 3 * ROW_PIXELS;
            end
            if (n > RANDOM_ITEMS - random_pixels)
                n = RANDOM_ITEMS - random_pixels;
            repeat (n)
            begin
                send_pixel(pick_pixel(), 1'b0, 8'd0);
                random_pixels++;
            end
            phase_count++;
        end

        in_valid <= 1'b0;
        while (pending_display.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (pending_display.size() != 0)
            note_failure($sformatf("%0d display items never arrived", pending_display.size()));

        $display("covered %0d pixels (%0d random) over %0d register phases",
                 pixels_sent, random_pixels, phase_count);
        $display("checked %0d display items in %0d rows, %0d frame wraps, %0d failures",
                 items_checked, rows_done, frames_done, fail_count);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
